### hdl/vit_pkg.sv
// ----------------------------------------------------------------------------
// vit_pkg
// Types shared by the visited interval tracker modules.
// ----------------------------------------------------------------------------
package vit_pkg;

    localparam int unsigned AddrW = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_FINISH
    } t_state;

    // One request after the front end: start, clipped inclusive end, zero length.
    typedef struct packed {
        logic [AddrW-1:0] start;
        logic [AddrW-1:0] last_addr;
        logic             zero;
    } t_item;

    typedef struct packed {
        logic [AddrW-1:0] start;
        logic [AddrW-1:0] length;
        logic             valid;
        logic             ovf;
        logic             last;
    } t_result;

endpackage

### hdl/vit_front.sv
// ----------------------------------------------------------------------------
// vit_front
// Accepts requests, computes the clipped end address and queues the item.
// ----------------------------------------------------------------------------
module vit_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [63:0]           i_start,
    input  logic [63:0]           i_length,
    output logic                  o_item_valid,
    output vit_pkg::t_item        o_item,
    input  logic                  i_pop
);
    import vit_pkg::*;

    t_item       r_q [2];
    logic        r_wr, n_wr;
    logic        r_rd, n_rd;
    logic [1:0]  r_count, n_count;
    logic [64:0] sum;
    t_item       item;
    logic        push;

    assign o_ready      = (r_count != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_q[r_rd];

    always_comb begin
        sum            = {1'b0, i_start} + {1'b0, i_length} - 65'd1;
        item.start     = i_start;
        // A range running past the top of the address space is clipped there.
        item.last_addr = sum[64] ? {AddrW{1'b1}} : sum[63:0];
        item.zero      = (i_length == 64'd0);
    end

    always_comb begin
        n_wr    = push ? ~r_wr : r_wr;
        n_rd    = i_pop ? ~r_rd : r_rd;
        n_count = r_count + {1'b0, push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= item;
        end
    end

endmodule

### hdl/vit_back.sv
// ----------------------------------------------------------------------------
// vit_back
// Walks the sorted interval table, reports uncovered pieces and rebuilds the
// table into the spare bank, one stored interval per cycle when not stalled.
// ----------------------------------------------------------------------------
module vit_back #(
    parameter int MAX_RANGES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  vit_pkg::t_item    i_item,
    output logic              o_pop,
    output logic              o_res_valid,
    output vit_pkg::t_result  o_res,
    input  logic              i_res_ready
);
    import vit_pkg::*;

    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int IW = $clog2(MAX_RANGES > 1 ? MAX_RANGES : 2);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_RANGES);
    localparam logic [AddrW-1:0] AllOnes = {AddrW{1'b1}};

    t_state r_state, n_state;
    logic          r_sel, n_sel;
    logic [CW-1:0] r_cnt, n_cnt, r_i, n_i, r_w, n_w;
    logic [AddrW-1:0] r_s, n_s, r_sl, n_sl, r_c, n_c, r_ns, n_ns, r_nl, n_nl;
    logic r_found, n_found, r_ins, n_ins, r_ovf, n_ovf, r_done, n_done;
    logic r_pv, n_pv, r_ovalid, n_ovalid;
    t_result r_pend, n_pend, r_out, n_out;
    logic [AddrW-1:0] r_rd_s, r_rd_l;

    // Two banks: the current table is read while the merged one is written.
    logic [AddrW-1:0] r_b0_s [MAX_RANGES];
    logic [AddrW-1:0] r_b0_l [MAX_RANGES];
    logic [AddrW-1:0] r_b1_s [MAX_RANGES];
    logic [AddrW-1:0] r_b1_l [MAX_RANGES];

    logic out_free, at_end, touch, below, ovf_now;
    logic wr_en, em;
    logic [AddrW-1:0] wr_s, wr_l, em_s, em_l;

    assign out_free    = !r_ovalid || i_res_ready;
    assign o_res_valid = r_ovalid;
    assign o_res       = r_out;
    assign o_pop       = (r_state == ST_IDLE) && i_item_valid && out_free;
    assign at_end      = (r_i == r_cnt);
    assign touch       = ((r_s == '0) || (r_rd_l >= r_s - 64'd1)) &&
                         ((r_sl == AllOnes) || (r_rd_s <= r_sl + 64'd1));
    assign below       = !touch && (r_rd_s < r_s);
    assign ovf_now     = !r_found && (r_cnt == MaxCnt);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_pop && !i_item.zero) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (out_free) begin
                    if (at_end) n_state = r_ins ? ST_FINISH : ST_INSERT;
                    else if (!touch && !below && !r_ins) n_state = ST_INSERT;
                end
            end
            ST_INSERT: begin
                if (out_free) n_state = ST_SCAN;
            end
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_sel = r_sel;   n_cnt = r_cnt;   n_i = r_i;     n_w = r_w;
        n_s = r_s;       n_sl = r_sl;     n_c = r_c;     n_ns = r_ns;   n_nl = r_nl;
        n_found = r_found; n_ins = r_ins; n_ovf = r_ovf; n_done = r_done;
        n_pv = r_pv;     n_pend = r_pend; n_out = r_out;
        n_ovalid = r_ovalid && !i_res_ready;
        wr_en = 1'b0;    wr_s = r_rd_s;   wr_l = r_rd_l;
        em = 1'b0;       em_s = r_c;      em_l = '0;
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    if (i_item.zero) begin
                        n_out    = '{start: '0, length: '0, valid: 1'b0, ovf: 1'b0,
                                     last: 1'b1};
                        n_ovalid = 1'b1;
                    end else begin
                        n_s = i_item.start;  n_sl = i_item.last_addr;
                        n_c = i_item.start;
                        n_found = 1'b0; n_ins = 1'b0; n_ovf = 1'b0; n_done = 1'b0;
                        n_pv = 1'b0; n_i = '0; n_w = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (out_free && !at_end) begin
                    if (below || (!touch && r_ins)) begin
                        wr_en = 1'b1;
                        n_w   = r_w + 1'b1;
                        n_i   = r_i + 1'b1;
                    end else if (touch) begin
                        n_found = 1'b1;
                        if (!r_found) n_ns = (r_rd_s < r_s) ? r_rd_s : r_s;
                        n_nl = (r_rd_l > r_sl) ? r_rd_l : r_sl;
                        if (!r_done && r_rd_s > r_c) begin
                            em   = 1'b1;
                            em_l = r_rd_s - r_c;
                        end
                        if (!r_done && r_rd_l >= r_c) begin
                            if (r_rd_l == AllOnes) n_done = 1'b1;
                            else n_c = r_rd_l + 64'd1;
                        end
                        n_i = r_i + 1'b1;
                    end
                end
            end
            ST_INSERT: begin
                if (out_free) begin
                    n_ins = 1'b1;
                    n_ovf = ovf_now;
                    if (!ovf_now) begin
                        wr_en = 1'b1;
                        wr_s  = r_found ? r_ns : r_s;
                        wr_l  = r_found ? r_nl : r_sl;
                        n_w   = r_w + 1'b1;
                        if (!r_done && r_c <= r_sl) begin
                            em   = 1'b1;
                            em_l = r_sl - r_c + 64'd1;
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    if (r_pv) begin
                        n_out      = r_pend;
                        n_out.last = 1'b1;
                    end else begin
                        n_out = '{start: '0, length: '0, valid: 1'b0, ovf: r_ovf,
                                  last: 1'b1};
                    end
                    n_ovalid = 1'b1;
                    n_pv     = 1'b0;
                    n_sel    = r_ovf ? r_sel : ~r_sel;
                    n_cnt    = r_ovf ? r_cnt : r_w;
                    n_i      = '0;
                end
            end
            default: ;
        endcase
        // Pieces are held back one slot so that the final one can carry last.
        if (em) begin
            if (r_pv) begin
                n_out    = r_pend;
                n_ovalid = 1'b1;
            end
            n_pend = '{start: em_s, length: em_l, valid: 1'b1, ovf: 1'b0, last: 1'b0};
            n_pv   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_sel    <= 1'b0;
            r_cnt    <= '0;
            r_i      <= '0;
            r_w      <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sel    <= n_sel;
            r_cnt    <= n_cnt;
            r_i      <= n_i;
            r_w      <= n_w;
            r_pv     <= n_pv;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;  r_sl <= n_sl;  r_c <= n_c;  r_ns <= n_ns;  r_nl <= n_nl;
        r_found <= n_found;  r_ins <= n_ins;  r_ovf <= n_ovf;  r_done <= n_done;
        r_pend <= n_pend;  r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (r_sel) begin
                r_b0_s[r_w[IW-1:0]] <= wr_s;
                r_b0_l[r_w[IW-1:0]] <= wr_l;
            end else begin
                r_b1_s[r_w[IW-1:0]] <= wr_s;
                r_b1_l[r_w[IW-1:0]] <= wr_l;
            end
        end
        if (n_sel) begin
            r_rd_s <= r_b1_s[n_i[IW-1:0]];
            r_rd_l <= r_b1_l[n_i[IW-1:0]];
        end else begin
            r_rd_s <= r_b0_s[n_i[IW-1:0]];
            r_rd_l <= r_b0_l[n_i[IW-1:0]];
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MaxCnt) else $error("interval count above table size");
    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w <= MaxCnt) else $error("write pointer beyond table");
    a_ovf_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.ovf |-> r_out.last && !r_out.valid)
        else $error("overflow result is not a lone final result");
    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) && out_free |=> r_ovalid && r_out.last)
        else $error("finished item produced no final result");
`endif

endmodule

### hdl/visited_interval_tracker_top.sv
// ----------------------------------------------------------------------------
// visited_interval_tracker_top
// Tracks visited address intervals and reports the unvisited parts of each
// requested range.
// ----------------------------------------------------------------------------
// Usage: a request on the s_axis channel carries range_start and range_length.
// For each request the m_axis channel returns one result per previously
// unvisited piece, lowest address first, with tlast on the final one; a
// request that adds nothing new, has zero length or finds the table full with
// no interval to merge into returns a single result with piece_valid clear
// (overflow set when full). Timing: the front end queues up to two requests;
// the back end walks the stored intervals (at most MAX_RANGES) one per clock.
// Zero-length requests skip the table walk. Reset empties the table at once;
// no clearing pass is needed. When the receiver holds m_axis_tready low the
// walk pauses, results are held and the request queue fills until
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module visited_interval_tracker_top #(
    parameter int MAX_RANGES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // range_start[63:0], range_length[127:64]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // piece_start[63:0], piece_length[127:64]
    output logic [1:0]    m_axis_tuser,   // piece_valid[0], overflow[1]
    output logic          m_axis_tlast
);
    import vit_pkg::*;

    logic    item_valid, pop;
    t_item   item;
    t_result res;

    vit_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_start      (s_axis_tdata[63:0]),
        .i_length     (s_axis_tdata[127:64]),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_pop        (pop)
    );

    vit_back #(.MAX_RANGES(MAX_RANGES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_pop        (pop),
        .o_res_valid  (m_axis_tvalid),
        .o_res        (res),
        .i_res_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {res.length, res.start};
    assign m_axis_tuser = {res.ovf, res.valid};
    assign m_axis_tlast = res.last;

endmodule

### tb/visited_interval_tracker_top_test.sv
// ----------------------------------------------------------------------------
// visited_interval_tracker_top_test
// Drives address ranges into the tracker and checks every returned piece
// against a local model of the sorted interval table, with random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module visited_interval_tracker_top_test;

    import vit_pkg::*;

    localparam int MaxRanges = 16;
    localparam int CycleLimit = 400000;
    localparam logic [63:0] AddrMax = 64'hFFFF_FFFF_FFFF_FFFF;

    // Field order matches s_axis_tdata: start in the low half.
    typedef struct packed {
        logic [63:0] length;
        logic [63:0] start;
    } t_range;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata;    // range_start[63:0], range_length[127:64]
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [127:0]  m_axis_tdata;    // piece_start[63:0], piece_length[127:64]
    logic [1:0]    m_axis_tuser;    // piece_valid[0], overflow[1]
    logic          m_axis_tlast;

    visited_interval_tracker_top #(.MAX_RANGES(MaxRanges)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    t_range    pending_ranges[$];
    t_result   expected_pieces[$];
    logic [63:0] tbl_start[MaxRanges];
    logic [63:0] tbl_len[MaxRanges];
    int        tbl_count;
    int        errors;
    int        cycles;
    bit        quiet;
    bit        hold_sender;
    int        src_idle;
    int        dst_idle;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [63:0] entry_end(int i);
        return tbl_start[i] + (tbl_len[i] - 64'd1);
    endfunction

    function automatic t_result mk(logic [63:0] st, logic [63:0] ln, logic v, logic o);
        t_result r;
        r.start = st; r.length = ln; r.valid = v; r.ovf = o; r.last = 1'b0;
        return r;
    endfunction

    // Computes the uncovered pieces of a range and merges or inserts it into the table.
    task automatic predict_visit(t_range rq);
        logic [63:0] s, sl, c, is, il, ns, ol, nl;
        logic [64:0] end65;
        int first, lastt, pos, drop, n;
        bit found, done, touch;
        s = rq.start; first = 0; lastt = 0; pos = 0; found = 0; done = 0; n = 0;
        if (rq.length == 0) begin
            expected_pieces.push_back(mk('0, '0, 1'b0, 1'b0));
            expected_pieces[$].last = 1'b1;
            return;
        end
        end65 = {1'b0, s} + {1'b0, rq.length} - 65'd1;
        sl = end65[64] ? AddrMax : end65[63:0];
        for (int i = 0; i < tbl_count; i++) begin
            is = tbl_start[i]; il = entry_end(i);
            touch = (s == 0 || il >= s - 64'd1) && (sl == AddrMax || is <= sl + 64'd1);
            if (is < s) pos++;
            if (touch) begin
                if (!found) first = i;
                found = 1; lastt = i;
            end
        end
        if (!found && tbl_count >= MaxRanges) begin
            expected_pieces.push_back(mk('0, '0, 1'b0, 1'b1));
            expected_pieces[$].last = 1'b1;
            return;
        end
        c = s;
        if (found) begin
            for (int i = first; i <= lastt; i++) begin
                is = tbl_start[i]; il = entry_end(i);
                if (!done && is > c) begin
                    expected_pieces.push_back(mk(c, is - c, 1'b1, 1'b0));
                    n++;
                end
                if (!done && il >= c) begin
                    if (il == AddrMax) done = 1;
                    else c = il + 64'd1;
                end
            end
        end
        if (!done && c <= sl) begin
            expected_pieces.push_back(mk(c, sl - c + 64'd1, 1'b1, 1'b0));
            n++;
        end
        if (found) begin
            ns = tbl_start[first] < s ? tbl_start[first] : s;
            ol = entry_end(lastt);
            nl = ol > sl ? ol : sl;
            drop = lastt - first;
            tbl_start[first] = ns;
            tbl_len[first] = nl - ns + 64'd1;
            for (int i = lastt + 1; i < tbl_count; i++) begin
                tbl_start[i - drop] = tbl_start[i];
                tbl_len[i - drop] = tbl_len[i];
            end
            tbl_count -= drop;
        end else begin
            for (int i = tbl_count; i > pos; i--) begin
                tbl_start[i] = tbl_start[i - 1];
                tbl_len[i] = tbl_len[i - 1];
            end
            tbl_start[pos] = s;
            tbl_len[pos] = sl - s + 64'd1;
            tbl_count++;
        end
        if (n == 0) expected_pieces.push_back(mk('0, '0, 1'b0, 1'b0));
        expected_pieces[$].last = 1'b1;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic add_range(logic [63:0] st, logic [63:0] ln);
        t_range r;
        r.start = st; r.length = ln;
        pending_ranges.push_back(r);
    endtask

    // Driver: one request held until accepted, random idle bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // Hold the current request.
        end else if (s_axis_tvalid && s_axis_tready && src_idle == 0 && !hold_sender
                     && pending_ranges.size() > 0 && !(!quiet && $urandom_range(0, 7) == 0)) begin
            s_axis_tdata <= pending_ranges.pop_front();
        end else if (src_idle > 0) begin
            s_axis_tvalid <= 1'b0;
            src_idle <= src_idle - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            src_idle <= $urandom_range(1, 15);
        end else if (!hold_sender && pending_ranges.size() > 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= pending_ranges.pop_front();
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // The prediction is made at the edge where a request is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) predict_visit(t_range'(s_axis_tdata));
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (dst_idle > 0) begin
            m_axis_tready <= 1'b0;
            dst_idle <= dst_idle - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            dst_idle <= $urandom_range(1, 15);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pieces.size() == 0) begin
                $display("%0t: unexpected result start=%h len=%h user=%b last=%b", $realtime,
                         m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser, m_axis_tlast);
                errors++;
            end else begin
                want = expected_pieces.pop_front();
                if (m_axis_tdata[63:0] !== want.start)
                    begin $display("%0t: piece_start expected %h actual %h", $realtime,
                                   want.start, m_axis_tdata[63:0]); errors++; end
                if (m_axis_tdata[127:64] !== want.length)
                    begin $display("%0t: piece_length expected %h actual %h", $realtime,
                                   want.length, m_axis_tdata[127:64]); errors++; end
                if (m_axis_tuser[0] !== want.valid)
                    begin $display("%0t: piece_valid expected %b actual %b", $realtime,
                                   want.valid, m_axis_tuser[0]); errors++; end
                if (m_axis_tuser[1] !== want.ovf)
                    begin $display("%0t: overflow expected %b actual %b", $realtime,
                                   want.ovf, m_axis_tuser[1]); errors++; end
                if (m_axis_tlast !== want.last)
                    begin $display("%0t: last expected %b actual %b", $realtime,
                                   want.last, m_axis_tlast); errors++; end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("[visited_interval_tracker_top] ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_ranges.size() > 0 || s_axis_tvalid || expected_pieces.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] base;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        errors = 0; cycles = 0; quiet = 0; hold_sender = 0; src_idle = 0; dst_idle = 0;
        tbl_count = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // Directed: gaps, merges, nothing new, top of space, whole space.
        add_range(64'h1000, 64'h10);
        add_range(64'h1020, 64'h10);
        add_range(64'h1000, 64'h40);       // fills the hole, extends past end
        add_range(64'h1008, 64'h8);        // nothing new
        add_range(64'h1040, 64'h1);        // touches on the right
        add_range(64'h0FFF, 64'h1);        // touches on the left
        add_range(64'h0, 64'h1);
        add_range(AddrMax, 64'h1);
        add_range(AddrMax - 64'h10, AddrMax);   // clipped at the top
        add_range(64'h5000, 64'h100);
        add_range(64'h5200, 64'h100);
        add_range(64'h4000, 64'h2000);     // spans several entries
        // Disjoint ranges fill the table; the last ones are refused as overflow.
        for (int k = 0; k < 14; k++)
            add_range(64'h10_0000 + 64'(k) * 64'h100, 64'h10);
        add_range(64'h10_0008, 64'h10);    // merges while the table is full
        add_range(64'h2000, 64'h0);        // zero length
        add_range(64'h0, AddrMax);         // whole space but the top address
        add_range(64'h123, 64'h1);         // nothing new in whole space
        add_range(64'h0, AddrMax);
        wait_drained();
        repeat (30) @(posedge i_clk);

        // The sender stops after these and waits until every result is back.
        for (int k = 0; k < 10; k++) add_range(rnd64(), rnd64());
        while (pending_ranges.size() > 0) @(posedge i_clk);
        hold_sender = 1;
        wait_drained();
        hold_sender = 0;
        // The table cannot be emptied without reset, so the random phase works
        // inside the covered space and checks that nothing new appears.
        for (int k = 0; k < 230; k++) begin
            base = rnd64();
            case ($urandom_range(0, 3))
                0: add_range(base, rnd64());
                1: add_range(base, 64'($urandom_range(1, 256)));
                2: add_range(AddrMax - 64'($urandom_range(0, 64)), 64'($urandom_range(1, 200)));
                default: add_range(64'($urandom_range(0, 4096)), 64'($urandom_range(1, 64)));
            endcase
        end
        // The final stretch runs without idle cycles on either side.
        while (pending_ranges.size() > 40) @(posedge i_clk);
        quiet = 1;
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && expected_pieces.size() == 0)
            $display("[visited_interval_tracker_top] OK");
        else
            $display("[visited_interval_tracker_top] ERROR");
        $finish;
    end

endmodule

### visited_interval_tracker_top.f
hdl/vit_pkg.sv
hdl/vit_front.sv
hdl/vit_back.sv
hdl/visited_interval_tracker_top.sv
tb/visited_interval_tracker_top_test.sv
